/* rtl/core/vt52csd_pkg.sv */
// Shared types and constants for the VT52 control sequence decoder.
// No dependencies; imported by every module of the decoder.
package vt52csd_pkg;

	// Character codes seen by the classifier
	localparam logic [6:0] CH_SPACE = 7'o040;
	localparam logic [6:0] CH_TAB   = 7'o011;
	localparam logic [6:0] CH_BS    = 7'o010;
	localparam logic [6:0] CH_LF    = 7'o012;
	localparam logic [6:0] CH_CR    = 7'o015;
	localparam logic [6:0] CH_ESC   = 7'o033;
	localparam logic [6:0] CH_BEL   = 7'o007;
	localparam logic [6:0] CH_A     = 7'h41;
	localparam logic [6:0] CH_B     = 7'h42;
	localparam logic [6:0] CH_C     = 7'h43;
	localparam logic [6:0] CH_D     = 7'h44;
	localparam logic [6:0] CH_F     = 7'h46;
	localparam logic [6:0] CH_G     = 7'h47;
	localparam logic [6:0] CH_H     = 7'h48;
	localparam logic [6:0] CH_I     = 7'h49;
	localparam logic [6:0] CH_J     = 7'h4A;
	localparam logic [6:0] CH_K     = 7'h4B;
	localparam logic [6:0] CH_Y     = 7'h59;

	// Longest burst of words one character may cause (a tab)
	localparam int MAX_RESULTS = 8;

	// Screen command codes on the result channel
	localparam logic [2:0] CMD_NONE         = 3'd0;
	localparam logic [2:0] CMD_DRAW         = 3'd1;
	localparam logic [2:0] CMD_SCROLL_UP    = 3'd2;
	localparam logic [2:0] CMD_SCROLL_DOWN  = 3'd3;
	localparam logic [2:0] CMD_CLEAR_SCREEN = 3'd4;
	localparam logic [2:0] CMD_CLEAR_LINE   = 3'd5;
	localparam logic [2:0] CMD_BELL         = 3'd6;

	// Escape sequence phase
	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESC    = 2'd1,
		PH_ROW    = 2'd2,
		PH_COL    = 2'd3
	} phase_t;

	// Classified operation handed from front to back
	typedef enum logic [3:0] {
		OP_NONE,
		OP_DRAW,
		OP_TAB,
		OP_LEFT,
		OP_RIGHT,
		OP_UP,
		OP_DOWN,
		OP_LF,
		OP_CR,
		OP_HOME,
		OP_RFEED,
		OP_CLR_SCR,
		OP_CLR_LINE,
		OP_BELL,
		OP_SET_ROW,
		OP_SET_COL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] ch;
	} entry_t;

endpackage

/* rtl/core/vt52csd_front.sv */
// Front end: accepts characters, tracks the escape phase, classifies each word.
// Depends on vt52csd_pkg.
module vt52csd_front import vt52csd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ch_valid,
	input  logic [6:0] ch,
	input  logic       full,
	output logic       push,
	output entry_t     push_entry
);

	phase_t phase_q;
	phase_t phase_nxt;
	logic   printable;

	assign printable = (ch >= CH_SPACE);
	assign push      = ch_valid && !full;

	// Classification and next phase
	always_comb begin
		phase_nxt        = PH_NORMAL;
		push_entry.op    = OP_NONE;
		push_entry.ch    = ch;
		case (phase_q)
			PH_ROW: begin
				push_entry.op = OP_SET_ROW;
				phase_nxt     = PH_COL;
			end
			PH_COL: begin
				push_entry.op = OP_SET_COL;
				phase_nxt     = PH_NORMAL;
			end
			PH_ESC: begin
				case (ch)
					CH_A: push_entry.op = OP_UP;
					CH_B: push_entry.op = OP_DOWN;
					CH_C: push_entry.op = OP_RIGHT;
					CH_D: push_entry.op = OP_LEFT;
					CH_F, CH_G: push_entry.op = OP_NONE;
					CH_H: push_entry.op = OP_HOME;
					CH_I: push_entry.op = OP_RFEED;
					CH_J: push_entry.op = OP_CLR_SCR;
					CH_K: push_entry.op = OP_CLR_LINE;
					CH_Y: begin
						push_entry.op = OP_NONE;
						phase_nxt     = PH_ROW;
					end
					// unknown: printable ones are drawn, control ones dropped
					default: push_entry.op = printable ? OP_DRAW : OP_NONE;
				endcase
			end
			default: begin
				if (printable) begin
					push_entry.op = OP_DRAW;
				end else begin
					case (ch)
						CH_TAB: push_entry.op = OP_TAB;
						CH_BS:  push_entry.op = OP_LEFT;
						CH_LF:  push_entry.op = OP_LF;
						CH_CR:  push_entry.op = OP_CR;
						CH_BEL: push_entry.op = OP_BELL;
						CH_ESC: begin
							push_entry.op = OP_NONE;
							phase_nxt     = PH_ESC;
						end
						default: push_entry.op = OP_NONE;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
		end else if (push) begin
			phase_q <= phase_nxt;
		end
	end

endmodule

/* rtl/core/vt52csd_queue.sv */
// Short flip-flop queue of classified words between front and back.
// Depends on vt52csd_pkg.
module vt52csd_queue import vt52csd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/vt52csd_back.sv */
// Back end: keeps the cursor, carries out classified words, drives the result register.
// Depends on vt52csd_pkg.
module vt52csd_back import vt52csd_pkg::*; #(
	parameter int LAST_COL = 79,
	parameter int LAST_ROW = 23,
	parameter int TAB_STOP = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] cmd,
	output logic [6:0] glyph,
	output logic [6:0] at_col,
	output logic [4:0] at_row,
	output logic [6:0] cursor_col,
	output logic [4:0] cursor_row,
	output logic       last
);

	localparam int ROW_W = $clog2(LAST_ROW + 1);

	logic [6:0]       col_q;
	logic [ROW_W-1:0] row_q;
	logic [2:0]       rem_q;
	logic             res_valid_q;

	logic             advance;
	logic             work;
	logic [2:0]       ex_cmd;
	logic [6:0]       ex_glyph;
	logic [6:0]       ex_col;
	logic [ROW_W-1:0] ex_row;
	logic [2:0]       ex_rem;
	logic             ex_last;
	logic [6:0]       coord;
	logic             coord_ok_row;
	logic             coord_ok_col;
	logic [31:0]      row_wide;
	logic [31:0]      ex_row_wide;
	logic [6:0]       col_inc;
	logic [3:0]       tab_n [128];

	// Spaces a tab draws from each column, capped at the burst limit
	for (genvar i = 0; i < 128; i++) begin : g_tab
		localparam int N  = TAB_STOP - (i % TAB_STOP);
		localparam int NC = (N > MAX_RESULTS) ? MAX_RESULTS : N;
		assign tab_n[i] = 4'(NC);
	end

	assign advance = !res_valid_q || !res_stall;
	assign work    = (rem_q != '0) || !empty;
	assign pop     = advance && (rem_q == '0) && !empty;
	assign col_inc = (col_q < 7'(LAST_COL)) ? col_q + 7'd1 : col_q;

	// Coordinate byte of a cursor address, offset by a space
	assign coord        = head.ch - CH_SPACE;
	assign coord_ok_row = (head.ch >= CH_SPACE) && (coord <= 7'(LAST_ROW));
	assign coord_ok_col = (head.ch >= CH_SPACE) && (coord <= 7'(LAST_COL));

	// Execute the head word, or the next space of a running tab
	always_comb begin
		ex_cmd   = CMD_NONE;
		ex_glyph = '0;
		ex_col   = col_q;
		ex_row   = row_q;
		ex_rem   = rem_q;
		ex_last  = 1'b1;
		if (rem_q != '0) begin
			ex_cmd   = CMD_DRAW;
			ex_glyph = CH_SPACE;
			ex_col   = col_inc;
			ex_rem   = rem_q - 3'd1;
			ex_last  = (rem_q == 3'd1);
		end else begin
			case (head.op)
				OP_DRAW: begin
					ex_cmd   = CMD_DRAW;
					ex_glyph = head.ch;
					ex_col   = col_inc;
				end
				OP_TAB: begin
					ex_cmd   = CMD_DRAW;
					ex_glyph = CH_SPACE;
					ex_col   = col_inc;
					ex_rem   = 3'(tab_n[col_q] - 4'd1);
					ex_last  = (tab_n[col_q] == 4'd1);
				end
				OP_LEFT:  if (col_q != '0) ex_col = col_q - 7'd1;
				OP_RIGHT: ex_col = col_inc;
				OP_UP:    if (row_q != '0) ex_row = row_q - 1'b1;
				OP_DOWN:  if (row_q < ROW_W'(LAST_ROW)) ex_row = row_q + 1'b1;
				OP_LF: begin
					if (row_q >= ROW_W'(LAST_ROW)) begin
						ex_cmd = CMD_SCROLL_UP;
					end else begin
						ex_row = row_q + 1'b1;
					end
				end
				OP_CR: ex_col = '0;
				OP_HOME: begin
					ex_col = '0;
					ex_row = '0;
				end
				OP_RFEED: begin
					if (row_q != '0) begin
						ex_row = row_q - 1'b1;
					end else begin
						ex_cmd = CMD_SCROLL_DOWN;
					end
				end
				OP_CLR_SCR:  ex_cmd = CMD_CLEAR_SCREEN;
				OP_CLR_LINE: ex_cmd = CMD_CLEAR_LINE;
				OP_BELL:     ex_cmd = CMD_BELL;
				OP_SET_ROW:  if (coord_ok_row) ex_row = ROW_W'(coord);
				OP_SET_COL:  if (coord_ok_col) ex_col = coord;
				default: ;
			endcase
		end
	end

	// Rows are reported in the five-bit field
	assign row_wide    = 32'(row_q);
	assign ex_row_wide = 32'(ex_row);

	// Cursor, tab counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			rem_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= work;
			if (work) begin
				col_q <= ex_col;
				row_q <= ex_row;
				rem_q <= ex_rem;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && work) begin
			cmd        <= ex_cmd;
			glyph      <= ex_glyph;
			at_col     <= col_q;
			at_row     <= row_wide[4:0];
			cursor_col <= ex_col;
			cursor_row <= ex_row_wide[4:0];
			last       <= ex_last;
		end
	end

	assign res_valid = res_valid_q;

endmodule

/* rtl/core/vt52_control_sequence_decoder_top.sv */
// VT52 control sequence decoder, top level.
// A character's words pass through the queue and then the result register before they are valid.
// Throughput: one result word per cycle from the back end while res_stall is low; a tab gives
// up to eight words, other characters one each.
// Reset: arst_n clears escape phase, cursor, queue and result valid at once.
// Depends on vt52csd_pkg, vt52csd_front, vt52csd_queue, vt52csd_back.
module vt52_control_sequence_decoder_top import vt52csd_pkg::*; #(
	parameter int LAST_COL    = 79,
	parameter int LAST_ROW    = 23,
	parameter int TAB_STOP    = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ch_valid,
	output logic       ch_stall,
	input  logic [6:0] ch,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] cmd,
	output logic [6:0] glyph,
	output logic [6:0] at_col,
	output logic [4:0] at_row,
	output logic [6:0] cursor_col,
	output logic [4:0] cursor_row,
	output logic       last
);

	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   empty;
	logic   full;

	assign ch_stall = full;

	vt52csd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch_valid   (ch_valid),
		.ch         (ch),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	vt52csd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	vt52csd_back #(
		.LAST_COL (LAST_COL),
		.LAST_ROW (LAST_ROW),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd),
		.glyph      (glyph),
		.at_col     (at_col),
		.at_row     (at_row),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.last       (last)
	);

endmodule

/* tb/vt52csd_checker.sv */
// Result checker for the VT52 control sequence decoder testbench.
// Watches both word channels, models cursor and escape phase, and compares each result word.
// Depends on vt52csd_pkg for character codes, command codes and phase_t.
module vt52csd_checker import vt52csd_pkg::*; #(
	parameter int LAST_COL = 79,
	parameter int LAST_ROW = 23,
	parameter int TAB_STOP = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ch_valid,
	input  logic       ch_stall,
	input  logic [6:0] ch,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic [2:0] cmd,
	input  logic [6:0] glyph,
	input  logic [6:0] at_col,
	input  logic [4:0] at_row,
	input  logic [6:0] cursor_col,
	input  logic [4:0] cursor_row,
	input  logic       last,
	output int         fail_count,
	output int         pending_words,
	output int         words_checked
);

	// One screen command word as the decoder should emit it
	typedef struct packed {
		logic [2:0] cmd;
		logic [6:0] glyph;
		logic [6:0] at_col;
		logic [4:0] at_row;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       last;
	} screen_word_t;

	screen_word_t expected_words [$];
	screen_word_t burst [MAX_RESULTS];
	screen_word_t oldest;
	int           burst_len;

	// Model of the decoder state
	phase_t     seq_phase = PH_NORMAL;
	logic [6:0] cur_col   = '0;
	logic [4:0] cur_row   = '0;

	initial begin
		fail_count    = 0;
		pending_words = 0;
		words_checked = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result word %0d: %s is %0d, expected %0d",
				words_checked, name, got, want));
	endtask

	// Add a word to the burst for the current character; cursor as it stands now
	task automatic add_word(input logic [2:0] code, input logic [6:0] g,
			input logic [6:0] acol, input logic [4:0] arow);
		if (burst_len < MAX_RESULTS) begin
			burst[burst_len] = '{code, g, acol, arow, cur_col, cur_row, 1'b0};
			burst_len++;
		end
	endtask

	// Draw at the cursor, then advance, holding at the last column
	task automatic draw_glyph(input logic [6:0] g);
		logic [6:0] c0;
		logic [4:0] r0;
		c0 = cur_col;
		r0 = cur_row;
		if (cur_col < LAST_COL)
			cur_col = cur_col + 1'b1;
		add_word(CMD_DRAW, g, c0, r0);
	endtask

	// Work out every word one character should cause
	task automatic predict_char(input logic [6:0] c);
		logic [6:0] c0;
		logic [4:0] r0;
		logic [2:0] code;
		logic       escaped_glyph;
		int         n;
		c0 = cur_col;
		r0 = cur_row;
		code = CMD_NONE;
		escaped_glyph = 1'b0;
		burst_len = 0;
		case (seq_phase)
			PH_ROW: begin
				// out-of-range row byte leaves the row alone
				if (c >= CH_SPACE && (c - CH_SPACE) <= LAST_ROW)
					cur_row = 5'(c - CH_SPACE);
				seq_phase = PH_COL;
				add_word(CMD_NONE, '0, c0, r0);
			end
			PH_COL: begin
				if (c >= CH_SPACE && (c - CH_SPACE) <= LAST_COL)
					cur_col = 7'(c - CH_SPACE);
				seq_phase = PH_NORMAL;
				add_word(CMD_NONE, '0, c0, r0);
			end
			PH_ESC: begin
				seq_phase = PH_NORMAL;
				case (c)
					CH_A: if (cur_row > 0) cur_row = cur_row - 1'b1;
					CH_B: if (cur_row < LAST_ROW) cur_row = cur_row + 1'b1;
					CH_C: if (cur_col < LAST_COL) cur_col = cur_col + 1'b1;
					CH_D: if (cur_col > 0) cur_col = cur_col - 1'b1;
					CH_F, CH_G: ;
					CH_H: begin
						cur_row = '0;
						cur_col = '0;
					end
					CH_I: if (cur_row > 0) cur_row = cur_row - 1'b1; else code = CMD_SCROLL_DOWN;
					CH_J: code = CMD_CLEAR_SCREEN;
					CH_K: code = CMD_CLEAR_LINE;
					CH_Y: seq_phase = PH_ROW;
					// unknown printable is drawn, unknown control is dropped
					default: escaped_glyph = (c >= CH_SPACE);
				endcase
				if (escaped_glyph)
					draw_glyph(c);
				else
					add_word(code, '0, c0, r0);
			end
			default: begin
				if (c >= CH_SPACE) begin
					draw_glyph(c);
				end else begin
					case (c)
						CH_TAB: begin
							n = TAB_STOP - (int'(cur_col) % TAB_STOP);
							if (n > MAX_RESULTS)
								n = MAX_RESULTS;
							for (int i = 0; i < n; i++)
								draw_glyph(CH_SPACE);
						end
						CH_BS: begin
							if (cur_col > 0)
								cur_col = cur_col - 1'b1;
							add_word(CMD_NONE, '0, c0, r0);
						end
						CH_LF: begin
							if (cur_row >= LAST_ROW)
								code = CMD_SCROLL_UP;
							else
								cur_row = cur_row + 1'b1;
							add_word(code, '0, c0, r0);
						end
						CH_CR: begin
							cur_col = '0;
							add_word(CMD_NONE, '0, c0, r0);
						end
						CH_ESC: begin
							seq_phase = PH_ESC;
							add_word(CMD_NONE, '0, c0, r0);
						end
						CH_BEL: add_word(CMD_BELL, '0, c0, r0);
						default: add_word(CMD_NONE, '0, c0, r0);
					endcase
				end
			end
		endcase
		if (burst_len == 0)
			add_word(CMD_NONE, '0, c0, r0);
		burst[burst_len - 1].last = 1'b1;
		for (int i = 0; i < burst_len; i++)
			expected_words.push_back(burst[i]);
	endtask

	// Compare result words first, then queue the words of a newly taken character
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = PH_NORMAL;
			cur_col = '0;
			cur_row = '0;
			expected_words.delete();
			pending_words <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("result word %0d with none outstanding, cmd %0d",
						words_checked, cmd));
				end else begin
					oldest = expected_words.pop_front();
					check_field("cmd", 8'(cmd), 8'(oldest.cmd));
					check_field("glyph", 8'(glyph), 8'(oldest.glyph));
					check_field("at_col", 8'(at_col), 8'(oldest.at_col));
					check_field("at_row", 8'(at_row), 8'(oldest.at_row));
					check_field("cursor_col", 8'(cursor_col), 8'(oldest.cursor_col));
					check_field("cursor_row", 8'(cursor_row), 8'(oldest.cursor_row));
					check_field("last", 8'(last), 8'(oldest.last));
				end
				words_checked++;
			end
			if (ch_valid && !ch_stall)
				predict_char(ch);
			pending_words <= expected_words.size();
		end
	end

endmodule

/* tb/tb.sv */
// Testbench top for the VT52 control sequence decoder.
// Drives characters and result stall with random idling; checking is in vt52csd_checker.
// Depends on vt52csd_pkg, vt52_control_sequence_decoder_top and vt52csd_checker.
module tb import vt52csd_pkg::*; ();

	localparam int LAST_COL  = 79;
	localparam int LAST_ROW  = 23;
	localparam int TAB_STOP  = 8;
	localparam int NUM_CHARS = 470;

	logic       clk;
	logic       arst_n;
	logic       ch_valid;
	logic       ch_stall;
	logic [6:0] ch;
	logic       res_valid;
	logic       res_stall;
	logic [2:0] cmd;
	logic [6:0] glyph;
	logic [6:0] at_col;
	logic [4:0] at_row;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic       last;

	int fail_count;
	int pending_words;
	int words_checked;
	int chars_sent = 0;
	int send_calm  = 0;
	int recv_calm  = 0;

	logic [6:0] directed [$];
	logic [6:0] esc_finals [10] = '{CH_A, CH_B, CH_C, CH_D, CH_F, CH_G, CH_H, CH_I, CH_J, CH_K};

	vt52_control_sequence_decoder_top #(
		.LAST_COL(LAST_COL),
		.LAST_ROW(LAST_ROW),
		.TAB_STOP(TAB_STOP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.ch_valid(ch_valid),
		.ch_stall(ch_stall),
		.ch(ch),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cmd(cmd),
		.glyph(glyph),
		.at_col(at_col),
		.at_row(at_row),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.last(last)
	);

	vt52csd_checker #(
		.LAST_COL(LAST_COL),
		.LAST_ROW(LAST_ROW),
		.TAB_STOP(TAB_STOP)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.ch_valid(ch_valid),
		.ch_stall(ch_stall),
		.ch(ch),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cmd(cmd),
		.glyph(glyph),
		.at_col(at_col),
		.at_row(at_row),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.last(last),
		.fail_count(fail_count),
		.pending_words(pending_words),
		.words_checked(words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, a few long, and now and then a calm stretch
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offer one character word and hold it until taken
	task automatic send_char(input logic [6:0] c);
		int gap;
		gap = idle_len(send_calm);
		if (gap > 0) begin
			ch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ch_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (ch_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	// Coordinate byte: mostly in range, sometimes anything at all
	function automatic logic [6:0] coord_byte(input int limit);
		if ($urandom_range(0, 9) == 0)
			return 7'($urandom_range(0, 127));
		return 7'(32 + $urandom_range(0, limit));
	endfunction

	// One random sequence: text, controls, escapes, addressing, broken escapes or noise
	task automatic send_random_sequence();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				n = $urandom_range(1, 6);
				repeat (n) send_char(7'($urandom_range(32, 127)));
			end
			3, 4: begin
				case ($urandom_range(0, 7))
					0: send_char(CH_TAB);
					1: send_char(CH_BS);
					2, 3: send_char(CH_LF);
					4: send_char(CH_CR);
					5: send_char(CH_BEL);
					default: send_char(7'($urandom_range(0, 31)));
				endcase
			end
			5, 6: begin
				send_char(CH_ESC);
				send_char(esc_finals[$urandom_range(0, 9)]);
			end
			7: begin
				send_char(CH_ESC);
				send_char(CH_Y);
				send_char(coord_byte(LAST_ROW));
				send_char(coord_byte(LAST_COL));
			end
			8: begin
				send_char(CH_ESC);
				send_char(7'($urandom_range(0, 127)));
			end
			default: send_char(7'($urandom_range(0, 127)));
		endcase
	endtask

	// Result side stall
	initial begin
		int hold;
		res_stall = 1'b0;
		@(posedge clk);
		forever begin
			hold = idle_len(recv_calm);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n = 1'b0;
		ch_valid = 1'b0;
		ch = '0;
		// clamps at every edge, each escape, bad coordinates, dropped and drawn escapes
		directed = '{CH_A, 7'h7F, CH_CR, CH_BS, CH_ESC, CH_A, CH_ESC, CH_I,
			CH_ESC, CH_Y, 7'(32 + LAST_ROW), 7'(32 + LAST_COL), CH_TAB, CH_LF,
			CH_ESC, CH_B, CH_ESC, CH_C, CH_ESC, CH_J, CH_ESC, CH_K, CH_ESC, CH_F,
			CH_ESC, CH_G, CH_ESC, CH_H, CH_ESC, CH_D, CH_ESC, CH_Y, 7'h1F, 7'h7F,
			CH_ESC, 7'h7A, CH_ESC, 7'h05, CH_ESC, CH_ESC, CH_BEL, 7'h00, CH_TAB};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_char(directed[i]);
		while (chars_sent < NUM_CHARS)
			send_random_sequence();
		ch_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		$display("Run covered %0d characters and %0d result words; %0d mismatches.",
			chars_sent, words_checked, fail_count);
		if (fail_count == 0 && pending_words == 0) begin
			$display("PASS vt52_control_sequence_decoder_top");
		end else begin
			$display("FAIL vt52_control_sequence_decoder_top");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#8000000;
		$display("Timed out with %0d result words outstanding.", pending_words);
		$display("FAIL vt52_control_sequence_decoder_top");
		$finish;
	end

endmodule
